FILE: rtl/gbn_pkg.sv
package gbn_pkg;

  localparam int SEQ_SPACE = 4;
  localparam int SEQ_W     = 2;
  localparam int PAY_W     = 32;
  localparam int CNT_W     = 2;
  localparam int TDATA_W   = 40;
  localparam int TUSER_W   = 3;

  localparam logic [1:0] ACT_RX   = 2'd0;
  localparam logic [1:0] ACT_SEND = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_DELIVER = 2'd1;
  localparam logic [1:0] KIND_REFUSE  = 2'd2;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_WINDOW  = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd3000000;
  localparam logic [1:0]  WINDOW_RESET  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    EM_DELIVER_ACK,
    EM_SEND,
    EM_REFUSE,
    EM_RESEND
  } emit_mode_t;

endpackage

FILE: rtl/go_back_n_link_endpoint_unit.sv
// Go-Back-N link endpoint, sequence numbers modulo four.
// Input stream: one event per request. tuser selects the event (receive, send,
// tick) and flags a received ack; tdata carries the sequence number and payload.
// Output stream: frames to transmit, payloads delivered upward and send refusals;
// tlast marks the final result of one input request.
// Configuration: cfg_we writes timeout_ticks (index 0) or window_limit (index 1).
// Sequencing: an accepted request is latched, passes a step state (tick counter
// update) and a decision state in the shared compare unit, then emits one result
// per cycle while out_tready allows; a request has no results or up to 3 (3 for
// a retransmit of the whole window). in_tready is high only in idle.
// The last result sits in the output register while the next request is taken.
// Stall: while out_tready is low the output register holds its result and the
// sequencer waits; the request after it waits at in_tready.
// Reset: window empty, all sequence numbers zero, timer cleared, registers at
// their reset values (timeout 3000000, window 3). The window store is not
// cleared; only entries written by a send are ever read.
module go_back_n_link_endpoint_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [gbn_pkg::TDATA_W-1:0] in_tdata,  // rx_seq, payload, zero fill
  input  logic [gbn_pkg::TUSER_W-1:0] in_tuser,  // action, rx_is_ack
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gbn_pkg::TDATA_W-1:0] out_tdata, // out_seq, out_payload, zero fill
  output logic [gbn_pkg::TUSER_W-1:0] out_tuser, // out_kind, out_is_ack
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_wdata
);

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int PW = gbn_pkg::PAY_W;
  localparam int CW = gbn_pkg::CNT_W;

  gbn_pkg::state_t     state_r, state_nxt;
  gbn_pkg::emit_mode_t mode_r, mode_nxt;

  logic [1:0]    act_r;
  logic          is_ack_r;
  logic [SW-1:0] seq_r;
  logic [PW-1:0] pay_r;

  logic [31:0]   timeout_r;
  logic [1:0]    window_limit_r;

  logic [SW-1:0] send_base_r;
  logic [SW-1:0] next_seq_r;
  logic [CW-1:0] outstanding_r;
  logic [SW-1:0] rx_expected_r;
  logic [31:0]   elapsed_r;

  logic [PW-1:0] window_store [gbn_pkg::SEQ_SPACE];

  logic [SW-1:0] emit_seq_r, emit_seq_nxt;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] last_idx_r, last_idx_nxt;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic          out_is_ack_r;
  logic [SW-1:0] out_seq_r;
  logic [PW-1:0] out_payload_r;
  logic          out_last_r;

  logic [31:0]   cmp_a, cmp_b;
  logic          cmp_ge;
  logic [SW-1:0] ack_dist;
  logic [2:0]    ack_span;
  logic          ack_ok, data_ok, send_ok, send_refuse, resend, has_result;
  logic          emit_load, emit_done;
  logic [1:0]    em_kind;
  logic          em_is_ack;
  logic [SW-1:0] em_seq;
  logic [PW-1:0] em_payload;
  logic          em_last;
  logic          em_from_store;
  logic [SW-1:0] window_sum;

  // shared compare unit
  assign cmp_ge = (cmp_a >= cmp_b);

  assign ack_dist = seq_r - send_base_r;
  assign ack_span = {1'b0, ack_dist} + 3'd1;

  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (act_r)
      gbn_pkg::ACT_RX: begin
        cmp_a = {{(32-CW){1'b0}}, outstanding_r};
        cmp_b = {29'd0, ack_span};
      end
      gbn_pkg::ACT_SEND: begin
        cmp_a = {{(32-CW){1'b0}}, outstanding_r};
        cmp_b = {30'd0, window_limit_r};
      end
      gbn_pkg::ACT_TICK: begin
        cmp_a = elapsed_r;
        cmp_b = timeout_r;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  always_comb begin
    ack_ok      = (act_r == gbn_pkg::ACT_RX) && is_ack_r && cmp_ge;
    data_ok     = (act_r == gbn_pkg::ACT_RX) && !is_ack_r && (seq_r == rx_expected_r);
    send_refuse = (act_r == gbn_pkg::ACT_SEND) && cmp_ge;
    send_ok     = (act_r == gbn_pkg::ACT_SEND) && !cmp_ge;
    resend      = (act_r == gbn_pkg::ACT_TICK) && (outstanding_r != '0) && cmp_ge;
    has_result  = data_ok || send_refuse || send_ok || resend;
    mode_nxt     = gbn_pkg::EM_REFUSE;
    emit_seq_nxt = '0;
    last_idx_nxt = '0;
    if (data_ok) begin
      mode_nxt     = gbn_pkg::EM_DELIVER_ACK;
      emit_seq_nxt = seq_r;
      last_idx_nxt = CW'(1);
    end else if (send_ok) begin
      mode_nxt     = gbn_pkg::EM_SEND;
      emit_seq_nxt = next_seq_r;
    end else if (resend) begin
      mode_nxt     = gbn_pkg::EM_RESEND;
      emit_seq_nxt = send_base_r;
      last_idx_nxt = outstanding_r - CW'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbn_pkg::ST_IDLE:   if (in_tvalid) state_nxt = gbn_pkg::ST_STEP;
      gbn_pkg::ST_STEP:   state_nxt = gbn_pkg::ST_DECIDE;
      gbn_pkg::ST_DECIDE: state_nxt = has_result ? gbn_pkg::ST_EMIT : gbn_pkg::ST_IDLE;
      gbn_pkg::ST_EMIT:   if (emit_done) state_nxt = gbn_pkg::ST_IDLE;
      default:            state_nxt = gbn_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      gbn_pkg::ST_IDLE: in_tready = 1'b1;
      gbn_pkg::ST_EMIT: emit_load = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        emit_load = 1'b0;
      end
    endcase
  end

  assign emit_done = emit_load && (idx_r == last_idx_r);

  // result formatting
  always_comb begin
    em_kind       = gbn_pkg::KIND_TX;
    em_is_ack     = 1'b0;
    em_seq        = emit_seq_r;
    em_payload    = pay_r;
    em_last       = (idx_r == last_idx_r);
    em_from_store = 1'b0;
    case (mode_r)
      gbn_pkg::EM_DELIVER_ACK: begin
        if (idx_r == '0) begin
          em_kind = gbn_pkg::KIND_DELIVER;
        end else begin
          em_is_ack  = 1'b1;
          em_payload = '0;
        end
      end
      gbn_pkg::EM_SEND: em_kind = gbn_pkg::KIND_TX;
      gbn_pkg::EM_REFUSE: begin
        em_kind    = gbn_pkg::KIND_REFUSE;
        em_seq     = '0;
        em_payload = '0;
      end
      gbn_pkg::EM_RESEND: begin
        em_seq        = emit_seq_r + SW'(idx_r);
        em_from_store = 1'b1;
      end
      default: em_kind = gbn_pkg::KIND_TX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r      <= gbn_pkg::TIMEOUT_RESET;
      window_limit_r <= gbn_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::REG_TIMEOUT: timeout_r      <= cfg_wdata;
        gbn_pkg::REG_WINDOW:  window_limit_r <= cfg_wdata[1:0];
        default:              timeout_r      <= timeout_r;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r    <= in_tuser[1:0];
      is_ack_r <= in_tuser[2];
      seq_r    <= in_tdata[SW-1:0];
      pay_r    <= in_tdata[SW+PW-1:SW];
    end
  end

  // link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_base_r   <= '0;
      next_seq_r    <= '0;
      outstanding_r <= '0;
      rx_expected_r <= '0;
      elapsed_r     <= '0;
      mode_r        <= gbn_pkg::EM_REFUSE;
      emit_seq_r    <= '0;
      idx_r         <= '0;
      last_idx_r    <= '0;
    end else begin
      case (state_r)
        gbn_pkg::ST_STEP: begin
          if (act_r == gbn_pkg::ACT_TICK && outstanding_r != '0 && elapsed_r != '1) begin
            elapsed_r <= elapsed_r + 32'd1;
          end
        end
        gbn_pkg::ST_DECIDE: begin
          mode_r     <= mode_nxt;
          emit_seq_r <= emit_seq_nxt;
          last_idx_r <= last_idx_nxt;
          idx_r      <= '0;
          if (ack_ok) begin
            send_base_r   <= seq_r + SW'(1);
            outstanding_r <= outstanding_r - ack_span[CW-1:0];
            elapsed_r     <= '0;
          end
          if (data_ok) begin
            rx_expected_r <= rx_expected_r + SW'(1);
          end
          if (send_ok) begin
            next_seq_r    <= next_seq_r + SW'(1);
            outstanding_r <= outstanding_r + CW'(1);
            elapsed_r     <= '0;
          end
          if (resend) begin
            next_seq_r <= send_base_r + SW'(outstanding_r);
            elapsed_r  <= '0;
          end
        end
        gbn_pkg::ST_EMIT: begin
          if (emit_load) begin
            idx_r <= idx_r + CW'(1);
          end
        end
        default: idx_r <= idx_r;
      endcase
    end
  end

  // window store
  always_ff @(posedge clk) begin
    if (state_r == gbn_pkg::ST_DECIDE && send_ok) begin
      window_store[next_seq_r] <= pay_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_kind_r    <= em_kind;
      out_is_ack_r  <= em_is_ack;
      out_seq_r     <= em_seq;
      out_payload_r <= em_from_store ? window_store[em_seq] : em_payload;
      out_last_r    <= em_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(gbn_pkg::TDATA_W-SW-PW){1'b0}}, out_payload_r, out_seq_r};
  assign out_tuser  = {out_is_ack_r, out_kind_r};
  assign out_tlast  = out_last_r;

  assign window_sum = send_base_r + SW'(outstanding_r);

  a_accept_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == gbn_pkg::ST_STEP))
    else $error("accepted request did not enter step");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_done |=> (state_r == gbn_pkg::ST_IDLE))
    else $error("sequencer kept emitting after the final result");

  a_window_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbn_pkg::ST_IDLE) |-> (next_seq_r == window_sum))
    else $error("next sequence number out of step with window");

  a_window_only_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gbn_pkg::ST_DECIDE) |=> ($stable(outstanding_r) && $stable(send_base_r)))
    else $error("window changed outside the decision cycle");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && out_valid_r) |-> out_tready)
    else $error("output register overwritten while stalled");

endmodule

FILE: bench/testbench.sv
module testbench;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_ack;
    logic [1:0]  seq;
    logic [31:0] payload;
    logic        last;
  } link_result_t;

  class endpoint_tracker;
    logic [31:0]  timeout_ticks = gbn_pkg::TIMEOUT_RESET;
    logic [1:0]   window_limit = gbn_pkg::WINDOW_RESET;
    logic [1:0]   send_base = '0;
    logic [1:0]   next_seq = '0;
    logic [1:0]   rx_expected = '0;
    int           outstanding = 0;
    logic [31:0]  elapsed = '0;
    logic [31:0]  window_store [gbn_pkg::SEQ_SPACE];
    link_result_t pending [$];
    int           mismatches = 0;

    function void note_config(logic idx, logic [31:0] value);
      if (idx == gbn_pkg::REG_TIMEOUT) timeout_ticks = value;
      else window_limit = value[1:0];
    endfunction

    function void push_result(logic [1:0] kind, logic is_ack, logic [1:0] seq,
                              logic [31:0] payload, logic last);
      link_result_t r;
      r.kind = kind;
      r.is_ack = is_ack;
      r.seq = seq;
      r.payload = payload;
      r.last = last;
      pending.push_back(r);
    endfunction

    function void note_request(logic [1:0] action, logic is_ack, logic [1:0] seq,
                               logic [31:0] payload);
      logic [1:0] dist_to_seq;
      logic [1:0] slot;
      case (action)
        gbn_pkg::ACT_RX: begin
          if (is_ack) begin
            dist_to_seq = seq - send_base;
            if (int'(dist_to_seq) < outstanding) begin
              send_base = send_base + dist_to_seq + 2'd1;
              outstanding -= int'(dist_to_seq) + 1;
              elapsed = '0;
            end
          end else if (seq == rx_expected) begin
            rx_expected = rx_expected + 2'd1;
            push_result(gbn_pkg::KIND_DELIVER, 1'b0, seq, payload, 1'b0);
            push_result(gbn_pkg::KIND_TX, 1'b1, seq, 32'd0, 1'b1);
          end
        end
        gbn_pkg::ACT_SEND: begin
          if (outstanding >= int'(window_limit)) begin
            push_result(gbn_pkg::KIND_REFUSE, 1'b0, 2'd0, 32'd0, 1'b1);
          end else begin
            window_store[next_seq] = payload;
            push_result(gbn_pkg::KIND_TX, 1'b0, next_seq, payload, 1'b1);
            next_seq = next_seq + 2'd1;
            outstanding++;
            elapsed = '0;
          end
        end
        gbn_pkg::ACT_TICK: begin
          if (outstanding != 0) begin
            if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 32'd1;
            if (elapsed >= timeout_ticks) begin
              for (int i = 0; i < outstanding; i++) begin
                slot = send_base + 2'(i);
                push_result(gbn_pkg::KIND_TX, 1'b0, slot, window_store[slot],
                            (i + 1 == outstanding));
              end
              next_seq = send_base + 2'(outstanding);
              elapsed = '0;
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(link_result_t got);
      link_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d ack %0d seq %0d payload %h last %0d",
                   got.kind, got.is_ack, got.seq, got.payload, got.last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected kind %0d ack %0d seq %0d payload %h last %0d,",
                    " got kind %0d ack %0d seq %0d payload %h last %0d"},
                   want.kind, want.is_ack, want.seq, want.payload, want.last,
                   got.kind, got.is_ack, got.seq, got.payload, got.last);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [gbn_pkg::TDATA_W-1:0]  in_tdata;
  logic [gbn_pkg::TUSER_W-1:0]  in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [gbn_pkg::TDATA_W-1:0]  out_tdata;
  logic [gbn_pkg::TUSER_W-1:0]  out_tuser;
  logic                         out_tlast;
  logic                         cfg_we;
  logic                         cfg_index;
  logic [31:0]                  cfg_wdata;

  endpoint_tracker tracker = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  go_back_n_link_endpoint_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk) begin
    link_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser[1:0];
      got.is_ack = out_tuser[2];
      got.seq = out_tdata[1:0];
      got.payload = out_tdata[33:2];
      got.last = out_tlast;
      tracker.check_result(got);
    end
  end

  task automatic push_request(logic [1:0] action, logic is_ack, logic [1:0] seq,
                              logic [31:0] payload);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = {is_ack, action};
    in_tdata = {6'd0, payload, seq};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(action, is_ack, seq, payload);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    wait_drained();
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    tracker.note_config(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] random_payload();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return 32'd0;
    if (pick == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic random_request();
    int pick;
    logic [1:0] seq;
    pick = $urandom_range(99);
    seq = 2'($urandom_range(3));
    if (pick < 30) begin
      push_request(gbn_pkg::ACT_SEND, 1'($urandom_range(1)), seq, random_payload());
    end else if (pick < 55) begin
      if (tracker.outstanding > 0 && $urandom_range(3) != 0)
        seq = tracker.send_base + 2'($urandom_range(tracker.outstanding - 1));
      push_request(gbn_pkg::ACT_RX, 1'b1, seq, random_payload());
    end else if (pick < 75) begin
      if ($urandom_range(9) < 7) seq = tracker.rx_expected;
      push_request(gbn_pkg::ACT_RX, 1'b0, seq, random_payload());
    end else if (pick < 95) begin
      push_request(gbn_pkg::ACT_TICK, 1'($urandom_range(1)), seq, random_payload());
    end else begin
      push_request(ACT_UNUSED, 1'($urandom_range(1)), seq, random_payload());
    end
  endtask

  initial begin
    logic [31:0] phase_timeout [4];
    logic [1:0]  phase_window [4];
    int          phase_idle [4];
    int          phase_stall [4];
    phase_timeout = '{32'd3, 32'd1, 32'hFFFF_FFFF, 32'd6};
    phase_window = '{2'd3, 2'd1, 2'd2, 2'd3};
    phase_idle = '{0, 87, 0, 20};
    phase_stall = '{0, 0, 87, 20};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = gbn_pkg::REG_TIMEOUT;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_request(gbn_pkg::ACT_RX, 1'b0, 2'd0, 32'd0);
    push_request(gbn_pkg::ACT_RX, 1'b0, 2'd0, 32'hFFFF_FFFF);
    push_request(gbn_pkg::ACT_RX, 1'b0, 2'd1, 32'hFFFF_FFFF);
    push_request(ACT_UNUSED, 1'b1, 2'd3, 32'hFFFF_FFFF);
    push_request(gbn_pkg::ACT_TICK, 1'b0, 2'd0, 32'd0);
    push_request(gbn_pkg::ACT_RX, 1'b1, 2'd2, 32'd0);
    push_request(gbn_pkg::ACT_SEND, 1'b0, 2'd0, 32'hFFFF_FFFF);
    push_request(gbn_pkg::ACT_SEND, 1'b1, 2'd3, 32'hA5A5_A5A5);
    push_request(gbn_pkg::ACT_SEND, 1'b0, 2'd1, 32'h5A5A_5A5A);
    push_request(gbn_pkg::ACT_SEND, 1'b0, 2'd2, 32'h1234_5678);
    push_request(gbn_pkg::ACT_TICK, 1'b0, 2'd0, 32'd0);
    push_request(gbn_pkg::ACT_RX, 1'b1, 2'd3, 32'd0);
    push_request(gbn_pkg::ACT_RX, 1'b1, 2'd0, 32'd0);
    push_request(gbn_pkg::ACT_RX, 1'b0, 2'd2, 32'hDEAD_BEEF);
    push_request(gbn_pkg::ACT_RX, 1'b0, 2'd3, 32'h0000_0001);
    push_request(gbn_pkg::ACT_RX, 1'b0, 2'd0, 32'h8000_0000);
    write_register(gbn_pkg::REG_TIMEOUT, 32'd0);
    write_register(gbn_pkg::REG_WINDOW, 32'd0);
    push_request(gbn_pkg::ACT_TICK, 1'b0, 2'd0, 32'd0);
    push_request(gbn_pkg::ACT_SEND, 1'b0, 2'd0, 32'h0BAD_F00D);
    write_register(gbn_pkg::REG_WINDOW, 32'd3);
    write_register(gbn_pkg::REG_TIMEOUT, 32'd1);
    push_request(gbn_pkg::ACT_SEND, 1'b0, 2'd0, 32'hCAFE_0003);
    push_request(gbn_pkg::ACT_TICK, 1'b0, 2'd0, 32'd0);
    push_request(gbn_pkg::ACT_RX, 1'b1, 2'd3, 32'd0);
    push_request(gbn_pkg::ACT_SEND, 1'b0, 2'd0, 32'hCAFE_0000);
    push_request(gbn_pkg::ACT_RX, 1'b1, 2'd0, 32'd0);

    for (int phase = 0; phase < 4; phase++) begin
      write_register(gbn_pkg::REG_TIMEOUT, phase_timeout[phase]);
      write_register(gbn_pkg::REG_WINDOW, 32'(phase_window[phase]));
      sender_idle_pct = phase_idle[phase];
      receiver_stall_pct = phase_stall[phase];
      for (int n = 0; n < 70; n++) begin
        if (n == 35) wait_drained();
        random_request();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #8000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: go_back_n_link_endpoint_unit.f
rtl/gbn_pkg.sv
rtl/go_back_n_link_endpoint_unit.sv
bench/testbench.sv
